// File: sv/eaq_pkg.sv
// Package for the Euler angle to quaternion core.
// Holds the CORDIC constants, the arctangent table and shared types.
package eaq_pkg;

    localparam int ATAN_COUNT = 24;
    localparam int CW = 34;

    typedef logic signed [CW-1:0] cval_t;

    typedef struct packed {
        cval_t x;
        cval_t y;
        cval_t z;
        logic  flip;
    } axis_t;

    localparam cval_t GAIN_Q30    = 34'sd652032874;
    localparam cval_t HALF_PI_Q30 = 34'sd1686629712;
    localparam cval_t PI_Q30      = 34'sd3373259424;

    function automatic cval_t atan_q30(input logic [4:0] idx);
        cval_t r;
        begin
            case (idx)
                5'd0: r = 34'sh3243F6A8;
                5'd1: r = 34'sh1DAC6705;
                5'd2: r = 34'sh0FADBAFC;
                5'd3: r = 34'sh07F56EA6;
                5'd4: r = 34'sh03FEAB76;
                5'd5: r = 34'sh01FFD55B;
                5'd6: r = 34'sh00FFFAAA;
                5'd7: r = 34'sh007FFF55;
                5'd8: r = 34'sh003FFFEA;
                5'd9: r = 34'sh001FFFFD;
                5'd10: r = 34'sh000FFFFF;
                5'd11: r = 34'sh0007FFFF;
                5'd12: r = 34'sh0003FFFF;
                5'd13: r = 34'sh0001FFFF;
                5'd14: r = 34'sh0000FFFF;
                5'd15: r = 34'sh00007FFF;
                5'd16: r = 34'sh00003FFF;
                5'd17: r = 34'sh00001FFF;
                5'd18: r = 34'sh00000FFF;
                5'd19: r = 34'sh000007FF;
                5'd20: r = 34'sh000003FF;
                5'd21: r = 34'sh000001FF;
                5'd22: r = 34'sh000000FF;
                5'd23: r = 34'sh0000007F;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: sv/eaq_cell.sv
// One CORDIC rotation cell: three axes, one iteration, registered.
// Depends on eaq_pkg.
module eaq_cell
    import eaq_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic  clk,
    input  logic  en,
    input  axis_t a_in [3],
    output axis_t a_out [3]
);

    axis_t a_reg [3];
    axis_t a_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a_next[k] = a_in[k];
            if (!a_in[k].z[CW-1])
            begin
                a_next[k].x = a_in[k].x - (a_in[k].y >>> STEP);
                a_next[k].y = a_in[k].y + (a_in[k].x >>> STEP);
                a_next[k].z = a_in[k].z - atan_q30(5'(STEP));
            end
            else
            begin
                a_next[k].x = a_in[k].x + (a_in[k].y >>> STEP);
                a_next[k].y = a_in[k].y - (a_in[k].x >>> STEP);
                a_next[k].z = a_in[k].z + atan_q30(5'(STEP));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
        end
    end

    assign a_out = a_reg;

endmodule

// File: sv/euler_angles_to_quaternion_core.sv
// Top level of the Euler angle to quaternion core.
// Depends on eaq_pkg and eaq_cell.
//
// Input channel: in_valid, in_stall with yaw_angle, pitch_angle, roll_angle
// (signed Q1.14 radians). Output channel: out_valid, out_stall with
// quat_scalar, quat_x, quat_y, quat_z (signed Q1.14, saturated to +/-1).
// One item enters per cycle while in_stall is low. The pipeline has one
// entry stage, one cell per CORDIC iteration, one rounding stage, one
// product stage and one output stage. Throughput is one item per cycle
// without stalls, set by the CORDIC cell chain and two multiplier stages.
// The whole pipeline advances together; when out_stall is high with a valid
// result waiting, the pipeline holds and in_stall rises.
// Reset clears all valid flags; payload registers are not reset.
module euler_angles_to_quaternion_core
    import eaq_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] yaw_angle,
    input  logic signed [15:0] pitch_angle,
    input  logic signed [15:0] roll_angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] quat_scalar,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z
);

    localparam int NS = (CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STEPS;
    localparam int NV = NS + 4;

    logic           adv;
    logic [NV-1:0]  v_reg;
    logic [NV-1:0]  v_next;
    axis_t          chain [NS+1][3];
    logic signed [15:0] ang [3];

    assign adv = !(v_reg[NV-1] && out_stall);
    assign in_stall = !adv;
    assign out_valid = v_reg[NV-1];

    assign v_next = {v_reg[NV-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= v_next;
        end
    end

    assign ang[0] = yaw_angle;
    assign ang[1] = pitch_angle;
    assign ang[2] = roll_angle;

    axis_t e_next [3];
    axis_t e_reg [3];
    cval_t zin [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            zin[k] = {{2{ang[k][15]}}, ang[k], 16'd0};
            e_next[k].x = GAIN_Q30;
            e_next[k].y = '0;
            e_next[k].flip = 1'b0;
            e_next[k].z = zin[k];
            if (zin[k] > HALF_PI_Q30)
            begin
                e_next[k].z = zin[k] - PI_Q30;
                e_next[k].flip = 1'b1;
            end
            else if (zin[k] < -HALF_PI_Q30)
            begin
                e_next[k].z = zin[k] + PI_Q30;
                e_next[k].flip = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg <= e_next;
        end
    end

    assign chain[0] = e_reg;

    for (genvar g = 0; g < NS; g++)
    begin : g_cell
        eaq_cell #(.STEP(g)) u_cell (
            .clk   (clk),
            .en    (adv),
            .a_in  (chain[g]),
            .a_out (chain[g+1])
        );
    end

    // Sine and cosine rounded to Q.16, after the quadrant flip.
    logic signed [17:0] s_next [3];
    logic signed [17:0] c_next [3];
    logic signed [17:0] s_reg [3];
    logic signed [17:0] c_reg [3];
    cval_t xf [3];
    cval_t yf [3];
    cval_t xr [3];
    cval_t yr [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            xf[k] = chain[NS][k].flip ? -chain[NS][k].x : chain[NS][k].x;
            yf[k] = chain[NS][k].flip ? -chain[NS][k].y : chain[NS][k].y;
            xr[k] = (xf[k] + 34'sd8192) >>> 14;
            yr[k] = (yf[k] + 34'sd8192) >>> 14;
            c_next[k] = xr[k][17:0];
            s_next[k] = yr[k][17:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg <= s_next;
            c_reg <= c_next;
        end
    end

    // Pair products of yaw and pitch, and roll terms carried along.
    logic signed [35:0] p_next [4];
    logic signed [35:0] p_reg [4];
    logic signed [17:0] sr_reg;
    logic signed [17:0] cr_reg;

    assign p_next[0] = c_reg[0] * c_reg[1];
    assign p_next[1] = s_reg[0] * s_reg[1];
    assign p_next[2] = s_reg[0] * c_reg[1];
    assign p_next[3] = c_reg[0] * s_reg[1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg  <= p_next;
            sr_reg <= s_reg[2];
            cr_reg <= c_reg[2];
        end
    end

    logic signed [54:0] d_next [4];
    logic signed [15:0] q_next [4];
    logic signed [15:0] q_reg [4];
    logic signed [54:0] rnd [4];

    assign d_next[0] = p_reg[0] * cr_reg - p_reg[1] * sr_reg;
    assign d_next[1] = p_reg[0] * sr_reg - p_reg[1] * cr_reg;
    assign d_next[2] = p_reg[2] * cr_reg - p_reg[3] * sr_reg;
    assign d_next[3] = p_reg[3] * cr_reg - p_reg[2] * sr_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rnd[k] = (d_next[k] + (55'sd1 <<< 33)) >>> 34;
            if (rnd[k] > 55'sd16384)
            begin
                q_next[k] = 16'sd16384;
            end
            else if (rnd[k] < -55'sd16384)
            begin
                q_next[k] = -16'sd16384;
            end
            else
            begin
                q_next[k] = rnd[k][15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg <= q_next;
        end
    end

    assign quat_scalar = q_reg[0];
    assign quat_x      = q_reg[1];
    assign quat_y      = q_reg[2];
    assign quat_z      = q_reg[3];

`ifndef NO_ASSERTIONS
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(quat_scalar)))
        else $error("result changed under stall");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output stall");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_x <= 16'sd16384 && quat_x >= -16'sd16384))
        else $error("component out of range");
`endif

endmodule
